FILE: rtl/core/p1305_pkg.sv
// Poly1305 MAC shared definitions: request payload types, widths, clamp masks
// and configuration register indexes. No dependencies.
package p1305_pkg;

  localparam int ACC_W  = 131;
  localparam int R_W    = 124;
  localparam int M_W    = 129;
  localparam int ADDR_W = 5;

  localparam logic [63:0] CLAMP_LO = 64'h0fff_fffc_0fff_ffff;
  localparam logic [63:0] CLAMP_HI = 64'h0fff_fffc_0fff_fffc;

  localparam logic [1:0] REG_R_LOW  = 2'd0;
  localparam logic [1:0] REG_R_HIGH = 2'd1;
  localparam logic [1:0] REG_S_LOW  = 2'd2;
  localparam logic [1:0] REG_S_HIGH = 2'd3;

  typedef struct packed {
    logic [63:0] block_low;
    logic [63:0] block_high;
    logic [4:0]  byte_count;
    logic        last;
  } msg_t;

  typedef struct packed {
    logic [63:0] tag_low;
    logic [63:0] tag_high;
  } tag_t;

endpackage

FILE: rtl/core/p1305_mul.sv
// Bit-serial multiplier modulo 2^130-5, one bit of r per cycle, MSB first.
// Depends on p1305_pkg.
module p1305_mul (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [p1305_pkg::ACC_W-1:0] a,
  input  logic [p1305_pkg::R_W-1:0]   r,
  output logic                      done,
  output logic [p1305_pkg::ACC_W-1:0] prod
);
  import p1305_pkg::*;

  localparam int CNT_W = $clog2(R_W);

  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] acc_next;
  logic [ACC_W-1:0] a_q;
  logic [R_W-1:0]   rsh;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [ACC_W+1:0] x;
  logic [2:0]       top;
  logic [4:0]       fold;

  // double, add, fold bits at 2^130 back in as times 5
  always_comb begin
    x        = {1'b0, acc, 1'b0} + {2'b0, (rsh[R_W-1] ? a_q : '0)};
    top      = x[ACC_W+1:ACC_W-1];
    fold     = {top, 2'b0} + {2'b0, top};
    acc_next = {1'b0, x[ACC_W-2:0]} + ACC_W'(fold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      a_q  <= a;
      rsh  <= r;
      acc  <= '0;
      cnt  <= CNT_W'(R_W - 1);
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      acc <= acc_next;
      rsh <= rsh << 1;
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign prod = acc;

endmodule

FILE: rtl/core/poly1305_mac.sv
// Poly1305 MAC top level: APB key registers, block padding, sequencer,
// freeze and tag output. Depends on p1305_pkg and p1305_mul.
//
// A block with a nonzero byte count holds msg_ready low from its acceptance
// until it is fully processed, so no new block is taken while one is in
// flight. The padded block is added to the accumulator and handed to the
// bit-serial multiplier, which walks the 124 bits of the clamped r one per
// cycle and then hands back the product. A non-last block then returns the
// sequencer to idle for the next request; a last block passes through
// freeze and the add of s before the tag is registered, and the tag state
// holds while an earlier tag still waits on the output. A zero-byte block
// skips the multiplier: a last one goes straight to freeze, and a non-last
// one is dropped at once. A new request is taken while a finished tag still
// waits on the output. Key registers are 64 bits at byte addresses 0, 8, 16
// and 24 (r low, r high, s low, s high); r is clamped on use and reads back
// as written.
module poly1305_mac (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [p1305_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready,
  input  logic                         msg_valid,
  output logic                         msg_ready,
  input  p1305_pkg::msg_t              msg,
  output logic                         tag_valid,
  input  logic                         tag_ready,
  output p1305_pkg::tag_t              tag
);
  import p1305_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_MUL,
    S_FREEZE,
    S_TAG
  } state_t;

  state_t           state;
  logic [63:0]      r_low, r_high, s_low, s_high;
  logic [ACC_W-1:0] acc;
  logic [M_W-1:0]   mpad;
  logic [M_W-1:0]   mpad_next;
  logic             last;
  logic [127:0]     fin;
  logic [127:0]     blk;
  logic [4:0]       n;
  logic [ACC_W-1:0] frz;
  logic             mul_start;
  logic             mul_done;
  logic [ACC_W-1:0] mul_prod;
  logic [ACC_W-1:0] mul_a;
  logic [R_W-1:0]   r_clamped;
  logic [127:0]     tag_sum;
  logic             wr;

  assign pready    = 1'b1;
  assign wr        = psel && penable && pwrite;
  assign msg_ready = (state == S_IDLE) && !rst;
  assign r_clamped = R_W'({r_high & CLAMP_HI, r_low & CLAMP_LO});
  assign mul_start = (state == S_ADD);
  assign mul_a     = acc + ACC_W'(mpad);
  assign frz       = acc + ACC_W'(5);
  assign tag_sum   = fin + {s_high, s_low};

  always_comb begin
    unique case (paddr[4:3])
      REG_R_LOW:  prdata = r_low;
      REG_R_HIGH: prdata = r_high;
      REG_S_LOW:  prdata = s_low;
      REG_S_HIGH: prdata = s_high;
      default:    prdata = '0;
    endcase
  end

  // keep counted bytes, then place the 0x01 pad byte right after them
  always_comb begin
    blk       = {msg.block_high, msg.block_low};
    n         = (msg.byte_count > 5'd16) ? 5'd16 : msg.byte_count;
    mpad_next = '0;
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < n) mpad_next[8*i +: 8] = blk[8*i +: 8];
    end
    for (int i = 0; i < 17; i++) begin
      if (5'(i) == n) mpad_next[8*i] = 1'b1;
    end
  end

  p1305_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .r     (r_clamped),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      r_low     <= '0;
      r_high    <= '0;
      s_low     <= '0;
      s_high    <= '0;
      acc       <= '0;
      tag_valid <= 1'b0;
      last      <= 1'b0;
    end else begin
      if (wr) begin
        unique case (paddr[4:3])
          REG_R_LOW:  r_low  <= pwdata;
          REG_R_HIGH: r_high <= pwdata;
          REG_S_LOW:  s_low  <= pwdata;
          REG_S_HIGH: s_high <= pwdata;
          default:    ;
        endcase
      end

      if (tag_valid && tag_ready && state != S_TAG) tag_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (msg_valid) begin
            mpad <= mpad_next;
            last <= msg.last;
            if (msg.byte_count != 5'd0) state <= S_ADD;
            else if (msg.last) state <= S_FREEZE;
          end
        end
        S_ADD: state <= S_MUL;
        S_MUL: begin
          if (mul_done) begin
            acc   <= mul_prod;
            state <= last ? S_FREEZE : S_IDLE;
          end
        end
        S_FREEZE: begin
          fin   <= frz[ACC_W-1] ? frz[127:0] : acc[127:0];
          state <= S_TAG;
        end
        S_TAG: begin
          if (!tag_valid || tag_ready) begin
            tag.tag_low  <= tag_sum[63:0];
            tag.tag_high <= tag_sum[127:64];
            tag_valid    <= 1'b1;
            acc          <= '0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
